// ===== rtl/variable_record_ring_queue_assert.svh =====
// ----------------------------------------------------------------------------
// variable_record_ring_queue assertion macros
// Shared property wrappers for the ring queue checks, clocked on clock
// and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef VARIABLE_RECORD_RING_QUEUE_ASSERT_SVH
`define VARIABLE_RECORD_RING_QUEUE_ASSERT_SVH

// condition must hold at every edge out of reset
`define VRQ_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("ring queue invariant violated");

// consequent must hold in the cycle after the antecedent
`define VRQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ring queue sequence violated");

`endif

// ===== rtl/vrq_pkg.sv =====
// ----------------------------------------------------------------------------
// vrq_pkg
// Types, sizes and helpers shared by the ring queue front, back and top.
// ----------------------------------------------------------------------------
package vrq_pkg;

   localparam int RING_MAX_BYTES   = 8192;
   localparam int HEADER_BYTES     = 16;
   localparam int MAX_RECORDS      = 512;
   localparam int CORE_ID_BITS     = 12;
   localparam int RING_RESET_BYTES = 4096;

   localparam int OFS_BITS      = 14;
   localparam int OUT_OFS_BITS  = 13;
   localparam int ARG_BITS      = 13;
   localparam int MODE_BITS     = 3;
   localparam int IDX_BITS      = $clog2(MAX_RECORDS);
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [MODE_BITS-1:0] MODE_PUSH        = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_PEEK        = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_POP         = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_POP_DISOWN  = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_OWN         = 3'd4;
   localparam logic [MODE_BITS-1:0] MODE_DISOWN      = 3'd5;

   // register index of ring_bytes, taken from paddr[2]
   localparam logic REG_RING_BYTES = 1'b0;

   typedef enum logic [2:0] {
      OP_PUSH        = 3'd0,
      OP_PEEK        = 3'd1,
      OP_POP         = 3'd2,
      OP_POP_DISOWN  = 3'd3,
      OP_OWN         = 3'd4,
      OP_DISOWN      = 3'd5,
      OP_BAD         = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_OWNER = 2'd1,
      STAT_EMPTY = 2'd2,
      STAT_SPACE = 2'd3
   } status_type;

   typedef struct packed {
      op_type                  op;
      logic [CORE_ID_BITS-1:0] core;
      logic [ARG_BITS-1:0]     arg;
   } cmd_type;

   typedef struct packed {
      logic                clear;
      logic [OFS_BITS-1:0] ring_bytes;
   } cfg_type;

   function automatic logic [IDX_BITS-1:0] next_idx(input logic [IDX_BITS-1:0] i);
      logic [IDX_BITS-1:0] r;
      if (i == IDX_BITS'(MAX_RECORDS - 1)) begin
         r = '0;
      end else begin
         r = i + IDX_BITS'(1);
      end
      return r;
   endfunction

endpackage

// ===== rtl/vrq_ram.sv =====
// ----------------------------------------------------------------------------
// vrq_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module vrq_ram #(
   parameter int WIDTH = 14,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/vrq_front.sv =====
// ----------------------------------------------------------------------------
// vrq_front
// Accepts request words, decodes the mode and holds them in a two-entry
// queue for the back end.
// ----------------------------------------------------------------------------
module vrq_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [vrq_pkg::MODE_BITS-1:0]    req_mode,
   input  logic [vrq_pkg::CORE_ID_BITS-1:0] req_core_id,
   input  logic [vrq_pkg::ARG_BITS-1:0]     req_arg_bytes,
   output logic                             cmd_valid,
   output vrq_pkg::cmd_type                 cmd,
   input  logic                             cmd_take
);

   vrq_pkg::cmd_type q_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             push;
   vrq_pkg::cmd_type decoded;

   always_comb begin
      unique case (req_mode)
         vrq_pkg::MODE_PUSH:       decoded.op = vrq_pkg::OP_PUSH;
         vrq_pkg::MODE_PEEK:       decoded.op = vrq_pkg::OP_PEEK;
         vrq_pkg::MODE_POP:        decoded.op = vrq_pkg::OP_POP;
         vrq_pkg::MODE_POP_DISOWN: decoded.op = vrq_pkg::OP_POP_DISOWN;
         vrq_pkg::MODE_OWN:        decoded.op = vrq_pkg::OP_OWN;
         vrq_pkg::MODE_DISOWN:     decoded.op = vrq_pkg::OP_DISOWN;
         default:                  decoded.op = vrq_pkg::OP_BAD;
      endcase
      decoded.core = req_core_id;
      decoded.arg  = req_arg_bytes;
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push     ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_take ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(cmd_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// ===== rtl/vrq_back.sv =====
// ----------------------------------------------------------------------------
// vrq_back
// Executes queued commands against the ring pointers, the owner and the
// record length FIFO, and holds the result word until it is taken.
// ----------------------------------------------------------------------------
module vrq_back (
   input  logic                             clock,
   input  logic                             reset,
   input  vrq_pkg::cfg_type                 cfg,
   input  logic                             cmd_valid,
   input  vrq_pkg::cmd_type                 cmd,
   output logic                             cmd_take,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [1:0]                       rsp_status,
   output logic [vrq_pkg::OUT_OFS_BITS-1:0] rsp_record_offset
);

   typedef enum logic [2:0] {
      BK_IDLE = 3'b001,
      BK_PUSH = 3'b010,
      BK_POP  = 3'b100
   } bk_state_type;

   bk_state_type state_ff, state_in;

   logic [vrq_pkg::OFS_BITS-1:0]     head_ff, head_in;
   logic [vrq_pkg::OFS_BITS-1:0]     tail_ff, tail_in;
   logic [vrq_pkg::OFS_BITS-1:0]     pad_ff, pad_in;
   logic [vrq_pkg::CORE_ID_BITS-1:0] owner_ff, owner_in;
   logic [vrq_pkg::IDX_BITS-1:0]     rd_idx_ff, rd_idx_in;
   logic [vrq_pkg::IDX_BITS-1:0]     wr_idx_ff, wr_idx_in;

   logic [vrq_pkg::OFS_BITS-1:0] len_ff, len_in;
   logic [vrq_pkg::OFS_BITS-1:0] after_ff, after_in;
   logic                         push_ok_ff, push_ok_in;
   logic                         tail_le_head_ff, tail_le_head_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   vrq_pkg::status_type              rsp_status_ff;
   logic [vrq_pkg::OUT_OFS_BITS-1:0] rsp_offset_ff;

   logic                             res_valid;
   vrq_pkg::status_type              res_status;
   logic [vrq_pkg::OUT_OFS_BITS-1:0] res_offset;

   logic                         out_free;
   logic                         ram_we;
   logic                         ram_re;
   logic [vrq_pkg::OFS_BITS-1:0] ram_rd_data;
   logic [vrq_pkg::OFS_BITS-1:0] span;
   logic [vrq_pkg::OFS_BITS-1:0] right;
   logic                         ring_empty;

   vrq_ram #(
      .WIDTH (vrq_pkg::OFS_BITS),
      .DEPTH (vrq_pkg::MAX_RECORDS)
   ) u_len_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_idx_ff),
      .wr_data (len_ff),
      .rd_en   (ram_re),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_rd_data)
   );

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign ring_empty = (head_ff == tail_ff);

   // largest contiguous free span of the ring
   always_comb begin
      right = (cfg.ring_bytes > tail_ff) ? cfg.ring_bytes - tail_ff : '0;
      if (tail_ff >= head_ff) begin
         span = (right >= head_ff) ? right : head_ff;
      end else begin
         span = head_ff - tail_ff;
      end
   end

   always_comb begin
      logic [vrq_pkg::OFS_BITS-1:0] at;
      logic [vrq_pkg::OFS_BITS-1:0] head_new;
      logic [vrq_pkg::OFS_BITS:0]   head_pad;

      state_in        = state_ff;
      head_in         = head_ff;
      tail_in         = tail_ff;
      pad_in          = pad_ff;
      owner_in        = owner_ff;
      rd_idx_in       = rd_idx_ff;
      wr_idx_in       = wr_idx_ff;
      len_in          = len_ff;
      after_in        = after_ff;
      push_ok_in      = push_ok_ff;
      tail_le_head_in = tail_le_head_ff;
      res_valid       = 1'b0;
      res_status      = vrq_pkg::STAT_OK;
      res_offset      = '0;
      ram_we          = 1'b0;
      ram_re          = 1'b0;
      at              = '0;
      head_new        = '0;
      head_pad        = '0;

      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid && out_free) begin
               unique case (cmd.op)
                  vrq_pkg::OP_PUSH: begin
                     len_in = vrq_pkg::OFS_BITS'(vrq_pkg::HEADER_BYTES)
                              + vrq_pkg::OFS_BITS'(cmd.arg);
                     push_ok_in = (len_in < span)
                                  && (vrq_pkg::next_idx(wr_idx_ff) != rd_idx_ff);
                     after_in        = right;
                     tail_le_head_in = (tail_ff <= head_ff);
                     state_in        = BK_PUSH;
                  end
                  vrq_pkg::OP_PEEK: begin
                     res_valid = 1'b1;
                     if (owner_ff != cmd.core) begin
                        res_status = vrq_pkg::STAT_OWNER;
                     end else if (ring_empty) begin
                        res_status = vrq_pkg::STAT_EMPTY;
                     end else begin
                        res_offset = head_ff[vrq_pkg::OUT_OFS_BITS-1:0];
                     end
                  end
                  vrq_pkg::OP_POP, vrq_pkg::OP_POP_DISOWN: begin
                     if (owner_ff != cmd.core) begin
                        res_valid  = 1'b1;
                        res_status = vrq_pkg::STAT_OWNER;
                     end else if (ring_empty) begin
                        res_valid  = 1'b1;
                        res_status = vrq_pkg::STAT_EMPTY;
                     end else begin
                        // fetch the head record length, finish next cycle
                        ram_re   = 1'b1;
                        state_in = BK_POP;
                     end
                  end
                  vrq_pkg::OP_OWN: begin
                     res_valid = 1'b1;
                     if (owner_ff != '0) begin
                        res_status = vrq_pkg::STAT_OWNER;
                     end else begin
                        owner_in = cmd.core;
                     end
                  end
                  vrq_pkg::OP_DISOWN: begin
                     res_valid = 1'b1;
                     if (owner_ff != cmd.core) begin
                        res_status = vrq_pkg::STAT_OWNER;
                     end else begin
                        owner_in = '0;
                     end
                  end
                  vrq_pkg::OP_BAD: begin
                     res_valid  = 1'b1;
                     res_status = vrq_pkg::STAT_OWNER;
                  end
               endcase
            end
         end
         BK_PUSH: begin
            res_valid = 1'b1;
            state_in  = BK_IDLE;
            if (!push_ok_ff) begin
               res_status = vrq_pkg::STAT_SPACE;
            end else begin
               if (tail_le_head_ff || (after_ff >= len_ff)) begin
                  at = tail_ff;
               end else begin
                  // pad out the end of the ring and wrap to zero
                  at     = '0;
                  pad_in = after_ff;
               end
               tail_in    = at + len_ff;
               ram_we     = 1'b1;
               wr_idx_in  = vrq_pkg::next_idx(wr_idx_ff);
               res_offset = at[vrq_pkg::OUT_OFS_BITS-1:0];
            end
         end
         BK_POP: begin
            res_valid = 1'b1;
            state_in  = BK_IDLE;
            head_new  = head_ff + ram_rd_data;
            head_pad  = {1'b0, head_new} + {1'b0, pad_ff};
            rd_idx_in = vrq_pkg::next_idx(rd_idx_ff);
            if (head_pad == {1'b0, cfg.ring_bytes}) begin
               head_new = '0;
               pad_in   = '0;
            end
            head_in = head_new;
            if (head_new == tail_ff) begin
               head_in   = '0;
               tail_in   = '0;
               pad_in    = '0;
               rd_idx_in = '0;
               wr_idx_in = '0;
            end
            if (cmd.op == vrq_pkg::OP_POP_DISOWN) begin
               owner_in = '0;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      // a ring size write drops every record
      if (cfg.clear) begin
         head_in   = '0;
         tail_in   = '0;
         pad_in    = '0;
         rd_idx_in = '0;
         wr_idx_in = '0;
      end

      rsp_valid_in = res_valid || (rsp_valid_ff && rsp_stall);
   end

   assign cmd_take = res_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         pad_ff       <= '0;
         owner_ff     <= '0;
         rd_idx_ff    <= '0;
         wr_idx_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         pad_ff       <= pad_in;
         owner_ff     <= owner_in;
         rd_idx_ff    <= rd_idx_in;
         wr_idx_ff    <= wr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff          <= len_in;
      after_ff        <= after_in;
      push_ok_ff      <= push_ok_in;
      tail_le_head_ff <= tail_le_head_in;
      if (res_valid) begin
         rsp_status_ff <= res_status;
         rsp_offset_ff <= res_offset;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_record_offset = rsp_offset_ff;

endmodule

// ===== rtl/variable_record_ring_queue.sv =====
// Sequence: peek, own and disown go from the idle state straight to the result register;
// push first passes through placement (BK_PUSH), pop through the length RAM read (BK_POP).
// Throughput: 1 item per cycle for peek/own/disown while the result is not stalled;
// push/pop hold the single back end execution sequencer busy until they finish.
// Reset: synchronous; pointers, owner and FIFO indices clear at once, ring_bytes
// returns to 4096, length RAM contents are left as they are (no clearing pass).
// ----------------------------------------------------------------------------
// variable_record_ring_queue
// Variable-length record ring with wrap padding, owner tracking and a
// length FIFO; front decodes and queues requests, back executes them.
// ----------------------------------------------------------------------------
module variable_record_ring_queue (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [vrq_pkg::MODE_BITS-1:0]     req_mode,
   input  logic [vrq_pkg::CORE_ID_BITS-1:0]  req_core_id,
   input  logic [vrq_pkg::ARG_BITS-1:0]      req_arg_bytes,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_status,
   output logic [vrq_pkg::OUT_OFS_BITS-1:0]  rsp_record_offset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [vrq_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [vrq_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [vrq_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready
);

   `include "variable_record_ring_queue_assert.svh"

   logic [vrq_pkg::OFS_BITS-1:0] ring_bytes_ff, ring_bytes_in;
   logic [vrq_pkg::OFS_BITS-1:0] wr_value;
   logic                         csr_write;
   vrq_pkg::cfg_type             cfg;
   logic                         cmd_valid;
   vrq_pkg::cmd_type             cmd;
   logic                         cmd_take;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == vrq_pkg::REG_RING_BYTES);
   assign wr_value   = csr_pwdata[vrq_pkg::OFS_BITS-1:0];

   always_comb begin
      ring_bytes_in = ring_bytes_ff;
      if (csr_write) begin
         // clamp to the storage size
         if (wr_value > vrq_pkg::OFS_BITS'(vrq_pkg::RING_MAX_BYTES)) begin
            ring_bytes_in = vrq_pkg::OFS_BITS'(vrq_pkg::RING_MAX_BYTES);
         end else begin
            ring_bytes_in = wr_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_bytes_ff <= vrq_pkg::OFS_BITS'(vrq_pkg::RING_RESET_BYTES);
      end else begin
         ring_bytes_ff <= ring_bytes_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == vrq_pkg::REG_RING_BYTES)
                       ? vrq_pkg::CSR_DATA_BITS'(ring_bytes_ff) : '0;

   assign cfg.clear      = csr_write;
   assign cfg.ring_bytes = ring_bytes_ff;

   vrq_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_core_id   (req_core_id),
      .req_arg_bytes (req_arg_bytes),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_take      (cmd_take)
   );

   vrq_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .cmd_valid         (cmd_valid),
      .cmd               (cmd),
      .cmd_take          (cmd_take),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_record_offset (rsp_record_offset)
   );

   `VRQ_ASSERT_ALWAYS(a_take_needs_cmd, !cmd_take || cmd_valid)
   `VRQ_ASSERT_NEXT(a_take_gives_rsp, cmd_take, rsp_valid)
   `VRQ_ASSERT_NEXT(a_rsp_drains, rsp_valid && !rsp_stall && !cmd_take, !rsp_valid)

endmodule
